// ===== design/raid5_read_reconstruct_top_defines.svh =====
// Assertion macros for the RAID5 read reconstruction block.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef RAID5_READ_RECONSTRUCT_TOP_DEFINES_SVH
`define RAID5_READ_RECONSTRUCT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/raid5rr_pkg.sv =====
// ----------------------------------------------------------------------------
// raid5rr_pkg
// Types, constants and codes shared by the RAID5 read reconstruction block.
// ----------------------------------------------------------------------------
package raid5rr_pkg;

    localparam int MAX_DISKS  = 16;
    localparam int MAX_BLOCKS = 1024;
    localparam int DISK_W     = $clog2(MAX_DISKS);
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int ADDR_W     = DISK_W + BLK_W;
    localparam int MEM_DEPTH  = MAX_DISKS * MAX_BLOCKS;
    localparam int WORD_W     = 32;
    localparam int LB_W       = 14;
    // The stripe span reaches 2047 * 15, one bit beyond a logical block number.
    localparam int SPAN_W     = LB_W + 1;
    localparam int NCNT_W     = 5;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(LB_W + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] ST_DIRECT  = 2'd0;
    localparam logic [1:0] ST_REBUILT = 2'd1;
    localparam logic [1:0] ST_UNAVAIL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIPE_BLOCKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

    typedef struct packed {
        logic                op;
        logic [3:0]          disk_number;
        logic [9:0]          block_index;
        logic [WORD_W-1:0]   load_word;
        logic [LB_W-1:0]     logical_block;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [WORD_W-1:0]   read_word;
    } t_out_item;

    typedef enum logic [1:0] {
        DIV_STRIPE,
        DIV_STRIP,
        DIV_ROT
    } t_div_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SPAN,
        S_D1_GO,
        S_D1_RUN,
        S_D2_GO,
        S_D2_RUN,
        S_D3_GO,
        S_D3_RUN,
        S_MAP,
        S_MAP2,
        S_CHECK,
        S_DIRECT,
        S_POST_DIRECT,
        S_REBUILD,
        S_RB_LAST,
        S_POST_RB,
        S_POST_NONE
    } t_state;

    typedef struct packed {
        logic       load_wr;
        logic       capture;
        logic       span_ld;
        logic       div_start;
        logic       div_take;
        t_div_sel   div_sel;
        logic       map_ld;
        logic       phys_ld;
        logic       rd_direct;
        logic       rb_init;
        logic       rb_step;
        logic       post;
        logic [1:0] post_status;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic in_range;
        logic data_present;
        logic rb_last;
        logic count_ok;
        logic out_free;
    } t_stat;

endpackage

// ===== design/raid5_read_reconstruct_top.sv =====
// A load is written in its accept cycle, and the input is ready again in the cycle after.
// A read computes the stripe span, runs three divisions on the shared divider, maps the block, then
// reads it directly, rebuilds it over n disks, or posts it as unavailable.
// One item is worked at a time; a finished result waits in the output register.
// Reset (synchronous, active low) clears the presence mask and sets the registers to
// their reset values; the disk store is not cleared.
// ----------------------------------------------------------------------------
// raid5_read_reconstruct_top
// RAID5 left-symmetric block reader with single-disk parity rebuild.
// ----------------------------------------------------------------------------
`include "raid5_read_reconstruct_top_defines.svh"

module raid5_read_reconstruct_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  raid5rr_pkg::t_in_item              i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output raid5rr_pkg::t_out_item             o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [raid5rr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [raid5rr_pkg::CFG_W-1:0]      i_cfg_data
);
    import raid5rr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    logic  load_take;
    logic  read_take;
    logic  status_known;

    raid5rr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in.op),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    raid5rr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_ready (i_out_ready)
    );

    assign load_take    = i_in_valid && o_in_ready && (i_in.op == OP_LOAD);
    assign read_take    = i_in_valid && o_in_ready && (i_in.op == OP_READ);
    assign status_known = (o_out.status == ST_DIRECT) || (o_out.status == ST_REBUILT) ||
                          (o_out.status == ST_UNAVAIL);

    // A load completes in its accept cycle, so the input is ready again at once.
    `RRR_ASSERT_NXT(a_load_one_cycle, load_take, o_in_ready, "load did not return to ready")
    // A read occupies the block, so no second beat is taken straight after it.
    `RRR_ASSERT_NXT(a_read_busy, read_take, !o_in_ready, "input ready straight after a read")
    `RRR_ASSERT_IMP(a_status_code, o_out_valid, status_known, "bad status code")
    `RRR_ASSERT_IMP(a_unavail_zero, o_out_valid && o_out.status == ST_UNAVAIL, o_out.read_word == '0, "unavailable result carries data")

endmodule

// ===== design/raid5rr_ctrl.sv =====
// ----------------------------------------------------------------------------
// raid5rr_ctrl
// Sequencer for loads and reads: address mapping, direct read or rebuild.
// ----------------------------------------------------------------------------
module raid5rr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_op,
    output logic                o_in_ready,
    input  raid5rr_pkg::t_stat  i_stat,
    output raid5rr_pkg::t_cmd   o_cmd
);
    import raid5rr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_SPAN;
                    end
                end
            end
            S_SPAN: begin
                o_cmd.span_ld = 1'b1;
                n_state       = S_D1_GO;
            end
            S_D1_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STRIPE;
                n_state         = S_D1_RUN;
            end
            S_D1_RUN: begin
                o_cmd.div_sel = DIV_STRIPE;
                if (!i_stat.div_busy) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_D2_GO;
                end
            end
            S_D2_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STRIP;
                n_state         = S_D2_RUN;
            end
            S_D2_RUN: begin
                o_cmd.div_sel = DIV_STRIP;
                if (!i_stat.div_busy) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_D3_GO;
                end
            end
            S_D3_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ROT;
                n_state         = S_D3_RUN;
            end
            S_D3_RUN: begin
                o_cmd.div_sel = DIV_ROT;
                if (!i_stat.div_busy) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.map_ld = 1'b1;
                n_state      = S_MAP2;
            end
            S_MAP2: begin
                o_cmd.phys_ld = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.in_range) begin
                    n_state = S_POST_NONE;
                end else if (i_stat.data_present) begin
                    n_state = S_DIRECT;
                end else begin
                    o_cmd.rb_init = 1'b1;
                    n_state       = S_REBUILD;
                end
            end
            S_DIRECT: begin
                o_cmd.rd_direct = 1'b1;
                n_state         = S_POST_DIRECT;
            end
            S_POST_DIRECT: begin
                o_cmd.post_status = ST_DIRECT;
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_REBUILD: begin
                o_cmd.rb_step = 1'b1;
                if (i_stat.rb_last) begin
                    n_state = S_RB_LAST;
                end
            end
            S_RB_LAST: begin
                // The last disk's word lands in the accumulator this cycle.
                n_state = S_POST_RB;
            end
            S_POST_RB: begin
                o_cmd.post_status = i_stat.count_ok ? ST_REBUILT : ST_UNAVAIL;
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_POST_NONE: begin
                o_cmd.post_status = ST_UNAVAIL;
                if (i_stat.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/raid5rr_dp.sv =====
// ----------------------------------------------------------------------------
// raid5rr_dp
// Datapath: configuration, disk store, shared divider, mapping and XOR rebuild.
// ----------------------------------------------------------------------------
module raid5rr_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  raid5rr_pkg::t_in_item                 i_in,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [raid5rr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [raid5rr_pkg::CFG_W-1:0]         i_cfg_data,
    input  raid5rr_pkg::t_cmd                     i_cmd,
    output raid5rr_pkg::t_stat                    o_stat,
    output logic                                  o_out_valid,
    output raid5rr_pkg::t_out_item                o_out,
    input  logic                                  i_out_ready
);
    import raid5rr_pkg::*;

    // Configuration registers.
    logic [NCNT_W-1:0]  r_disk_count;
    logic [CFG_W-1:0]   r_stripe_blocks;
    logic [CFG_W-1:0]   r_blocks_in_use;

    logic [NCNT_W-1:0]  n_eff;
    logic [CFG_W-1:0]   s_eff;
    logic [CFG_W-1:0]   used_eff;

    // Disk store and presence.
    logic [WORD_W-1:0]    mem [MEM_DEPTH];
    logic [MAX_DISKS-1:0] r_present;
    logic [WORD_W-1:0]    r_rd_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;

    // Mapping registers.
    logic [LB_W-1:0]    r_lb;
    logic [SPAN_W-1:0]  r_span;
    logic [LB_W-1:0]    r_stripe;
    logic [LB_W-1:0]    r_rem1;
    logic [DISK_W-1:0]  r_q2;
    logic [CFG_W-1:0]   r_off;
    logic [DISK_W-1:0]  r_rot;
    logic [DISK_W-1:0]  r_parity;
    logic [LB_W-1:0]    r_base;
    logic [LB_W-1:0]    r_phys;
    logic [DISK_W-1:0]  r_data;
    logic [NCNT_W-1:0]  data_sum;

    // Divider.
    logic [LB_W-1:0]      r_drem;
    logic [LB_W-1:0]      r_dquo;
    logic [SPAN_W-1:0]    r_ddiv;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [LB_W:0]        d_trial;
    logic                 d_ge;
    logic [LB_W-1:0]      div_dividend;
    logic [SPAN_W-1:0]    div_divisor;

    // Rebuild loop.
    logic [DISK_W-1:0]  r_idx;
    logic               r_acc_en;
    logic [WORD_W-1:0]  r_acc;
    logic [NCNT_W-1:0]  r_pcnt;

    // Output register.
    logic               r_out_vld;
    t_out_item          r_out;
    logic               out_free;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_eff = r_disk_count;
        if (r_disk_count < NCNT_W'(2)) begin
            n_eff = NCNT_W'(2);
        end else if (r_disk_count > NCNT_W'(MAX_DISKS)) begin
            n_eff = NCNT_W'(MAX_DISKS);
        end
        s_eff    = (r_stripe_blocks == '0) ? CFG_W'(1) : r_stripe_blocks;
        used_eff = (r_blocks_in_use > CFG_W'(MAX_BLOCKS)) ? CFG_W'(MAX_BLOCKS)
                                                          : r_blocks_in_use;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_count    <= NCNT_W'(2);
            r_stripe_blocks <= CFG_W'(1);
            r_blocks_in_use <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DISK_COUNT:    r_disk_count    <= i_cfg_data[NCNT_W-1:0];
                CFG_STRIPE_BLOCKS: r_stripe_blocks <= i_cfg_data;
                CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Store writes and reads; the read port is registered.
    assign rd_en   = i_cmd.rd_direct | i_cmd.rb_step;
    assign rd_addr = i_cmd.rb_step ? {r_idx, r_phys[BLK_W-1:0]}
                                   : {r_data, r_phys[BLK_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) begin
            mem[{i_in.disk_number, i_in.block_index}] <= i_in.load_word;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (i_cmd.load_wr) begin
            r_present[i_in.disk_number] <= 1'b1;
        end
    end

    // Shared restoring divider, one quotient bit per cycle.
    always_comb begin
        case (i_cmd.div_sel)
            DIV_STRIPE: begin
                div_dividend = r_lb;
                div_divisor  = r_span;
            end
            DIV_STRIP: begin
                div_dividend = r_rem1;
                div_divisor  = SPAN_W'(s_eff);
            end
            DIV_ROT: begin
                div_dividend = r_stripe;
                div_divisor  = SPAN_W'(n_eff);
            end
            default: begin
                div_dividend = r_lb;
                div_divisor  = r_span;
            end
        endcase
    end

    // The partial remainder never exceeds the dividend, so it fits LB_W bits
    // even when the divisor does not.
    assign d_trial = {r_drem, r_dquo[LB_W-1]};
    assign d_ge    = d_trial >= r_ddiv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            r_dcnt <= DIV_CNT_W'(LB_W);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_drem <= '0;
            r_dquo <= div_dividend;
            r_ddiv <= div_divisor;
        end else if (r_dcnt != '0) begin
            r_drem <= d_ge ? LB_W'(d_trial - r_ddiv) : d_trial[LB_W-1:0];
            r_dquo <= {r_dquo[LB_W-2:0], d_ge};
        end
    end

    // Mapping.  The partial offset is below the disk count, so one subtract
    // of the disk count brings the data disk into range.
    assign data_sum = NCNT_W'(r_parity) + NCNT_W'(1) + NCNT_W'(r_q2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lb <= i_in.logical_block;
        end
        if (i_cmd.span_ld) begin
            r_span <= SPAN_W'(s_eff) * SPAN_W'(n_eff - NCNT_W'(1));
        end
        if (i_cmd.div_take) begin
            case (i_cmd.div_sel)
                DIV_STRIPE: begin
                    r_stripe <= r_dquo;
                    r_rem1   <= r_drem;
                end
                DIV_STRIP: begin
                    r_q2  <= r_dquo[DISK_W-1:0];
                    r_off <= r_drem[CFG_W-1:0];
                end
                DIV_ROT: begin
                    r_rot <= r_drem[DISK_W-1:0];
                end
                default: ;
            endcase
        end
        if (i_cmd.map_ld) begin
            r_parity <= DISK_W'(n_eff - NCNT_W'(1) - NCNT_W'(r_rot));
            r_base   <= LB_W'(r_stripe) * LB_W'(s_eff);
        end
        if (i_cmd.phys_ld) begin
            r_phys <= LB_W'(r_base + LB_W'(r_off));
            r_data <= (data_sum >= n_eff) ? DISK_W'(data_sum - n_eff)
                                          : data_sum[DISK_W-1:0];
        end
    end

    // Rebuild: one disk read per cycle, with the XOR in the cycle after the read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_en <= 1'b0;
        end else begin
            r_acc_en <= i_cmd.rb_step & r_present[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rb_init) begin
            r_idx  <= '0;
            r_acc  <= '0;
            r_pcnt <= '0;
        end else begin
            if (i_cmd.rb_step) begin
                r_idx  <= r_idx + DISK_W'(1);
                r_pcnt <= r_pcnt + NCNT_W'(r_present[r_idx]);
            end
            if (r_acc_en) begin
                r_acc <= r_acc ^ r_rd_data;
            end
        end
    end

    // Result register.
    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out.status <= i_cmd.post_status;
            case (i_cmd.post_status)
                ST_DIRECT:  r_out.read_word <= r_rd_data;
                ST_REBUILT: r_out.read_word <= r_acc;
                default:    r_out.read_word <= '0;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    always_comb begin
        o_stat.div_busy     = (r_dcnt != '0);
        o_stat.in_range     = (r_phys < LB_W'(used_eff));
        o_stat.data_present = r_present[r_data];
        o_stat.rb_last      = (NCNT_W'(r_idx) == (n_eff - NCNT_W'(1)));
        o_stat.count_ok     = (r_pcnt == (n_eff - NCNT_W'(1)));
        o_stat.out_free     = out_free;
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RAID5 left-symmetric block reader. Loads and
// reads are queued phase by phase and driven over a valid/ready channel, and
// each read result is checked against a predictor that keeps its own disk
// store, presence mask and register copies. Register settings change between
// phases, and flow control on both sides is varied from phase to phase.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import raid5rr_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned LB_MAX        = (1 << LB_W) - 1;

    // Index 3 maps to no register and must be ignored by the block.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } t_pace;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_beat   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_beat;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_DISK_COUNT;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Predictor state, updated as beats are accepted.
    logic [WORD_W-1:0]    array_words [MEM_DEPTH];
    logic [MAX_DISKS-1:0] array_present = '0;
    logic [NCNT_W-1:0]    reg_disks     = 5'd2;
    logic [CFG_W-1:0]     reg_strip     = 11'd1;
    logic [CFG_W-1:0]     reg_used      = 11'd1;

    // Stimulus-side view of what has been loaded, updated as beats are queued.
    bit                   gen_loaded [MEM_DEPTH];
    logic [MAX_DISKS-1:0] gen_present = '0;
    int unsigned          gen_disks   = 2;
    int unsigned          gen_strip   = 1;
    int unsigned          gen_used    = 1;

    t_in_item             beat_queue [$];
    t_out_item            expected_reads [$];
    int unsigned          beats_queued  = 0;
    int unsigned          beats_taken   = 0;
    int unsigned          error_count   = 0;
    int unsigned          cycle_count   = 0;
    int unsigned          src_idle_pct  = 0;
    int unsigned          snk_stall_pct = 0;

    raid5_read_reconstruct_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void locate_block(input int unsigned lb, nraw, sraw, uraw,
                                         output int unsigned n, data, phys, used, span);
        int unsigned s;
        int unsigned stripe;
        int unsigned parity;
        n      = (nraw < 2) ? 2 : ((nraw > MAX_DISKS) ? MAX_DISKS : nraw);
        s      = (sraw == 0) ? 1 : sraw;
        used   = (uraw > MAX_BLOCKS) ? MAX_BLOCKS : uraw;
        span   = s * (n - 1);
        stripe = lb / span;
        parity = n - 1 - (stripe % n);
        data   = (parity + 1 + (lb % span) / s) % n;
        phys   = (lb % s) + stripe * s;
    endfunction

    function automatic t_out_item predict_read(input logic [LB_W-1:0] lb);
        t_out_item         r;
        int unsigned       n, data, phys, used, span, hits, i;
        logic [WORD_W-1:0] acc;
        locate_block(lb, reg_disks, reg_strip, reg_used, n, data, phys, used, span);
        r.status    = ST_UNAVAIL;
        r.read_word = '0;
        hits        = 0;
        acc         = '0;
        if (phys < used) begin
            if (array_present[data]) begin
                r.status    = ST_DIRECT;
                r.read_word = array_words[data * MAX_BLOCKS + phys];
            end else begin
                for (i = 0; i < n; i++) begin
                    if (array_present[i]) begin
                        hits++;
                        acc ^= array_words[i * MAX_BLOCKS + phys];
                    end
                end
                if (hits == n - 1) begin
                    r.status    = ST_REBUILT;
                    r.read_word = acc;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_beat(input t_in_item b);
        beat_queue = {beat_queue, b};
        beats_queued++;
    endtask

    task automatic queue_load(input int unsigned disk, blk, input logic [WORD_W-1:0] word);
        t_in_item b;
        b.op            = OP_LOAD;
        b.disk_number   = 4'(disk);
        b.block_index   = 10'(blk);
        b.load_word     = word;
        b.logical_block = LB_W'($urandom_range(0, LB_MAX));
        gen_loaded[disk * MAX_BLOCKS + blk] = 1'b1;
        gen_present[disk] = 1'b1;
        queue_beat(b);
    endtask

    task automatic queue_read(input int unsigned lb);
        t_in_item    b;
        int unsigned n, data, phys, used, span, i;
        locate_block(lb, gen_disks, gen_strip, gen_used, n, data, phys, used, span);
        // Every word that this read can fetch is loaded first, so that no
        // never-written block is ever read.
        if (phys < used) begin
            if (gen_present[data]) begin
                if (!gen_loaded[data * MAX_BLOCKS + phys]) begin
                    queue_load(data, phys, $urandom);
                end
            end else begin
                for (i = 0; i < n; i++) begin
                    if (gen_present[i] && !gen_loaded[i * MAX_BLOCKS + phys]) begin
                        queue_load(i, phys, $urandom);
                    end
                end
            end
        end
        b.op            = OP_READ;
        b.disk_number   = 4'($urandom_range(0, 15));
        b.block_index   = 10'($urandom_range(0, 1023));
        b.load_word     = $urandom;
        b.logical_block = LB_W'(lb);
        queue_beat(b);
    endtask

    task automatic queue_random(input int unsigned count, input logic [MAX_DISKS-1:0] load_disks);
        int unsigned       k, n, data, phys, used, span, s, lim, disk, blk;
        logic [WORD_W-1:0] word;
        locate_block(0, gen_disks, gen_strip, gen_used, n, data, phys, used, span);
        s   = span / (n - 1);
        // Most reads land in the stripes that hold loaded blocks.
        lim = ((used + s - 1) / s + 1) * span;
        if (lim > LB_MAX) begin
            lim = LB_MAX;
        end
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 9) < 7) begin
                    queue_read($urandom_range(0, lim));
                end else begin
                    queue_read($urandom_range(0, LB_MAX));
                end
            end else begin
                do begin
                    disk = $urandom_range(0, MAX_DISKS - 1);
                end while (!load_disks[disk]);
                if ($urandom_range(0, 4) != 0 && used > 0) begin
                    blk = $urandom_range(0, used - 1);
                end else begin
                    blk = $urandom_range(0, MAX_BLOCKS - 1);
                end
                case ($urandom_range(0, 9))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                queue_load(disk, blk, word);
            end
        end
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (!(beats_taken == beats_queued && expected_reads.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_registers(input int unsigned disks, strip, used);
        logic [CFG_W-1:0]     vals [4];
        logic [CFG_IDX_W-1:0] idx [4];
        int unsigned          i;
        idx[0]  = CFG_DISK_COUNT;
        idx[1]  = CFG_STRIPE_BLOCKS;
        idx[2]  = CFG_BLOCKS_IN_USE;
        idx[3]  = CFG_SPARE;
        // Only the low five bits of the disk count are kept.
        vals[0] = {6'($urandom_range(0, 63)), 5'(disks)};
        vals[1] = CFG_W'(strip);
        vals[2] = CFG_W'(used);
        vals[3] = CFG_W'($urandom_range(0, 2047));
        gen_disks = disks;
        gen_strip = strip;
        gen_used  = used;
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx[0];
        cfg_data  <= vals[0];
        i = 0;
        while (i < 4) begin
            @(posedge i_clk);
            if (cfg_ready) begin
                case (cfg_index)
                    CFG_DISK_COUNT:    reg_disks = cfg_data[NCNT_W-1:0];
                    CFG_STRIPE_BLOCKS: reg_strip = cfg_data;
                    CFG_BLOCKS_IN_USE: reg_used  = cfg_data;
                    default: ;
                endcase
                i++;
                if (i < 4) begin
                    cfg_index <= idx[i];
                    cfg_data  <= vals[i];
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    endtask

    task automatic run_phase(input int unsigned disks, strip, used,
                             input logic [MAX_DISKS-1:0] load_disks,
                             input int unsigned count, input t_pace pace, input bit hold_midway);
        wait_idle();
        // Loads give no result, so the last one may still be in flight.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_registers(disks, strip, used);
        case (pace)
            PACE_SRC_IDLE:  begin src_idle_pct = 78; snk_stall_pct = 0;  end
            PACE_SNK_STALL: begin src_idle_pct = 0;  snk_stall_pct = 78; end
            PACE_BOTH:      begin src_idle_pct = 10; snk_stall_pct = 10; end
            default:        begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        endcase
        if (hold_midway) begin
            queue_random(count / 2, load_disks);
            wait_idle();
            queue_random(count - count / 2, load_disks);
        end else begin
            queue_random(count, load_disks);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (beat_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                in_valid <= 1'b1;
                in_beat  <= beat_queue.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                beats_taken++;
                if (in_beat.op == OP_LOAD) begin
                    array_words[{in_beat.disk_number, in_beat.block_index}] = in_beat.load_word;
                    array_present[in_beat.disk_number] = 1'b1;
                end else begin
                    expected_reads = {expected_reads, predict_read(in_beat.logical_block)};
                end
            end
            if (out_valid && out_ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch($sformatf("result beat with no read outstanding: %h",
                                              out_beat));
                end else begin
                    want = expected_reads.pop_front();
                    if (out_beat.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_beat.status, want.status));
                    end
                    if (out_beat.read_word !== want.read_word) begin
                        report_mismatch($sformatf("read_word %h, expected %h",
                                                  out_beat.read_word, want.read_word));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: two disks, one block per strip, one block in use.
        queue_read(0);
        queue_read(LB_MAX);
        queue_load(1, 0, '1);
        queue_read(0);
        queue_load(0, 0, '0);
        queue_read(0);
        queue_read(1);
        // Disk 15 lies beyond the disk count and must not take part in reads.
        queue_load(15, MAX_BLOCKS - 1, 32'h5A5A_A5A5);
        queue_read(0);

        // Disk count and strip size of zero, and no blocks in use at all.
        run_phase(0, 0, 0, '0, 0, PACE_FREE, 1'b0);
        queue_read(0);
        queue_read(3);

        // Disk count and blocks in use above their maxima, oversized strips.
        run_phase(31, 2047, 2047, '0, 0, PACE_FREE, 1'b0);
        queue_read(1023);
        queue_read(1024);
        queue_read(2047);
        queue_read(4094);
        queue_read(LB_MAX);

        // The presence mask only grows, so the phases add disks in order.
        run_phase(3, 1, 8, 16'h0003, 130, PACE_FREE, 1'b0);
        run_phase(4, 2, 16, 16'h0007, 150, PACE_SRC_IDLE, 1'b1);
        run_phase(5, 3, 12, 16'h000F, 150, PACE_SNK_STALL, 1'b0);
        run_phase(8, 4, 32, 16'h00BF, 150, PACE_BOTH, 1'b0);
        run_phase(16, 8, 64, 16'h3FFF, 150, PACE_FREE, 1'b0);
        run_phase(1, 0, 5, 16'h0003, 100, PACE_SRC_IDLE, 1'b0);
        // Disk 14 stays absent here, so its blocks are rebuilt over 15 disks.
        run_phase(31, 1024, 1024, 16'h0001, 80, PACE_SNK_STALL, 1'b0);
        run_phase(16, 1, 1, 16'hC000, 100, PACE_BOTH, 1'b0);
        run_phase(6, 7, 100, 16'hFFFF, 100, PACE_FREE, 1'b0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
